### rtl/clfr_pkg.sv
// Shared types and constants for the clean-first LRU replacer.
package clfr_pkg;

  localparam int NUM_FRAMES_DEF = 64;
  localparam int FRAME_W        = 6;
  localparam int COUNT_W        = 7;
  localparam int IN_TDATA_W     = 8;
  localparam int IN_TUSER_W     = 3;
  localparam int OUT_TDATA_W    = 16;

  typedef enum logic [1:0] {
    ACT_VICTIM = 2'd0,
    ACT_PIN    = 2'd1,
    ACT_UNPIN  = 2'd2
  } action_t;

  // Controller to datapath: one step of the item's sequence.
  typedef struct packed {
    logic accept;
    logic eval;
    logic link;
    logic finish;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic unlink;
  } stat_t;

endpackage

### rtl/clfr_ctrl.sv
// Sequencing controller: accepts an item, steps the datapath, owns out valid.
module clfr_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  output logic           out_tvalid,
  input  logic           out_tready,
  output clfr_pkg::cmd_t cmd,
  input  clfr_pkg::stat_t stat
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_LINK,
    S_DONE
  } state_t;

  state_t state_r;
  logic   out_valid_r;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    cmd.accept = (state_r == S_IDLE) && in_tvalid;
    cmd.eval   = (state_r == S_EVAL);
    cmd.link   = (state_r == S_LINK);
    cmd.finish = (state_r == S_DONE) && (!out_valid_r || out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) state_r <= S_EVAL;
        end
        S_EVAL: begin
          // an unlink needs the link words read this cycle
          state_r <= stat.unlink ? S_LINK : S_DONE;
        end
        S_LINK: begin
          state_r <= S_DONE;
        end
        S_DONE: begin
          // hold while the previous result is still waiting
          if (!out_valid_r || out_tready) state_r <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/clfr_dp.sv
// Datapath: frame flags, list heads and counts, link memories, result register.
module clfr_dp #(
  parameter int NUM_FRAMES = clfr_pkg::NUM_FRAMES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  clfr_pkg::cmd_t                cmd,
  output clfr_pkg::stat_t               stat,
  input  logic [1:0]                    in_action,
  input  logic [clfr_pkg::FRAME_W-1:0]  in_frame,
  input  logic                          in_dirty,
  output logic                          out_found,
  output logic [clfr_pkg::FRAME_W-1:0]  out_victim,
  output logic [clfr_pkg::COUNT_W-1:0]  out_count
);

  // Only frames the frame field can name are ever touched.
  localparam int DEPTH = (NUM_FRAMES < (1 << clfr_pkg::FRAME_W)) ?
                         NUM_FRAMES : (1 << clfr_pkg::FRAME_W);
  localparam int FW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  // latched item
  clfr_pkg::action_t           act_r;
  logic [clfr_pkg::FRAME_W-1:0] frame_r;
  logic                        dirty_r;

  // per-frame flags
  logic [DEPTH-1:0] pinned_r, pinned_nxt;
  logic [DEPTH-1:0] dlist_r,  dlist_nxt;

  // list heads and counts
  logic [FW-1:0] c_new_r, c_new_nxt, c_old_r, c_old_nxt;
  logic [FW-1:0] d_new_r, d_new_nxt, d_old_r, d_old_nxt;
  logic [CW-1:0] c_cnt_r, c_cnt_nxt, d_cnt_r, d_cnt_nxt;

  // pending unlink
  logic [FW-1:0] tgt_r, tgt_nxt;
  logic          tlist_r, tlist_nxt;
  logic          found_r, found_nxt;

  // link memories
  logic [FW-1:0] older_mem [DEPTH];
  logic [FW-1:0] newer_mem [DEPTH];
  logic [FW-1:0] older_rd_r, newer_rd_r;
  logic          o_we, n_we;
  logic [FW-1:0] o_wa, o_wd, n_wa, n_wd;

  // result register
  logic                         res_found_r;
  logic [clfr_pkg::FRAME_W-1:0] res_victim_r;
  logic [clfr_pkg::COUNT_W-1:0] res_count_r;

  // decode
  logic          frame_ok;
  logic [FW-1:0] fidx;
  logic          do_unlink, do_push;
  logic [FW-1:0] tgt;
  logic          tlist;

  // list being updated
  logic          lsel;
  logic [CW-1:0] cnt_sel, cnt_upd;
  logic [FW-1:0] new_sel, new_upd, old_sel, old_upd;
  logic          is_old, is_new, older_ok, newer_ok;
  logic [CW:0]   cnt_sum;

  assign fidx     = frame_r[FW-1:0];
  assign frame_ok = (int'(frame_r) < DEPTH);

  always_comb begin
    do_unlink = 1'b0;
    do_push   = 1'b0;
    tgt       = fidx;
    tlist     = dlist_r[fidx];
    unique case (act_r)
      clfr_pkg::ACT_VICTIM: begin
        // clean frames go first
        if (c_cnt_r != '0) begin
          do_unlink = 1'b1;
          tgt       = c_old_r;
          tlist     = 1'b0;
        end else if (d_cnt_r != '0) begin
          do_unlink = 1'b1;
          tgt       = d_old_r;
          tlist     = 1'b1;
        end
      end
      clfr_pkg::ACT_PIN: begin
        do_unlink = frame_ok && !pinned_r[fidx];
      end
      clfr_pkg::ACT_UNPIN: begin
        do_push = frame_ok && pinned_r[fidx];
      end
      default: begin
      end
    endcase
  end

  assign stat.unlink = do_unlink;

  always_comb begin
    pinned_nxt = pinned_r;
    dlist_nxt  = dlist_r;
    c_new_nxt  = c_new_r;
    c_old_nxt  = c_old_r;
    c_cnt_nxt  = c_cnt_r;
    d_new_nxt  = d_new_r;
    d_old_nxt  = d_old_r;
    d_cnt_nxt  = d_cnt_r;
    tgt_nxt    = tgt_r;
    tlist_nxt  = tlist_r;
    found_nxt  = found_r;
    o_we       = 1'b0;
    o_wa       = fidx;
    o_wd       = fidx;
    n_we       = 1'b0;
    n_wa       = fidx;
    n_wd       = fidx;

    lsel     = cmd.link ? tlist_r : dirty_r;
    cnt_sel  = lsel ? d_cnt_r : c_cnt_r;
    new_sel  = lsel ? d_new_r : c_new_r;
    old_sel  = lsel ? d_old_r : c_old_r;
    cnt_upd  = cnt_sel;
    new_upd  = new_sel;
    old_upd  = old_sel;
    is_old   = (old_sel == tgt_r);
    is_new   = (new_sel == tgt_r);
    older_ok = (int'(older_rd_r) < DEPTH);
    newer_ok = (int'(newer_rd_r) < DEPTH);

    if (cmd.eval) begin
      found_nxt = do_unlink && (act_r == clfr_pkg::ACT_VICTIM);
      tgt_nxt   = tgt;
      tlist_nxt = tlist;
      if (do_unlink) pinned_nxt[tgt] = 1'b1;
      if (do_push) begin
        pinned_nxt[fidx] = 1'b0;
        dlist_nxt[fidx]  = dirty_r;
        if (cnt_sel == '0) begin
          old_upd = fidx;
        end else begin
          // append behind the current newest
          n_we = 1'b1;
          n_wa = new_sel;
          n_wd = fidx;
          o_we = 1'b1;
          o_wa = fidx;
          o_wd = new_sel;
        end
        new_upd = fidx;
        cnt_upd = cnt_sel + CW'(1);
      end
    end

    if (cmd.link) begin
      if (cnt_sel == CW'(1)) begin
        cnt_upd = '0;
      end else if (cnt_sel != '0) begin
        if (is_old) begin
          old_upd = newer_rd_r;
        end else if (older_ok) begin
          n_we = 1'b1;
          n_wa = older_rd_r;
          n_wd = is_new ? older_rd_r : newer_rd_r;
        end
        if (is_new) begin
          new_upd = older_rd_r;
        end else if (newer_ok) begin
          o_we = 1'b1;
          o_wa = newer_rd_r;
          o_wd = is_old ? newer_rd_r : older_rd_r;
        end
        cnt_upd = cnt_sel - CW'(1);
      end
    end

    if (lsel) begin
      d_cnt_nxt = cnt_upd;
      d_new_nxt = new_upd;
      d_old_nxt = old_upd;
    end else begin
      c_cnt_nxt = cnt_upd;
      c_new_nxt = new_upd;
      c_old_nxt = old_upd;
    end
  end

  assign cnt_sum = {1'b0, c_cnt_r} + {1'b0, d_cnt_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pinned_r <= '1;
      dlist_r  <= '0;
      c_new_r  <= '0;
      c_old_r  <= '0;
      c_cnt_r  <= '0;
      d_new_r  <= '0;
      d_old_r  <= '0;
      d_cnt_r  <= '0;
      found_r  <= 1'b0;
    end else begin
      pinned_r <= pinned_nxt;
      dlist_r  <= dlist_nxt;
      c_new_r  <= c_new_nxt;
      c_old_r  <= c_old_nxt;
      c_cnt_r  <= c_cnt_nxt;
      d_new_r  <= d_new_nxt;
      d_old_r  <= d_old_nxt;
      d_cnt_r  <= d_cnt_nxt;
      found_r  <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tgt_r   <= tgt_nxt;
    tlist_r <= tlist_nxt;
    if (cmd.accept) begin
      act_r   <= clfr_pkg::action_t'(in_action);
      frame_r <= in_frame;
      dirty_r <= in_dirty;
    end
    if (cmd.finish) begin
      res_found_r  <= found_r;
      res_victim_r <= found_r ? clfr_pkg::FRAME_W'(tgt_r) : '0;
      res_count_r  <= clfr_pkg::COUNT_W'(cnt_sum);
    end
  end

  // link memories: read at the target during eval, write one word each
  always_ff @(posedge clk) begin
    older_rd_r <= older_mem[tgt];
    newer_rd_r <= newer_mem[tgt];
    if (o_we) older_mem[o_wa] <= o_wd;
    if (n_we) newer_mem[n_wa] <= n_wd;
  end

  assign out_found  = res_found_r;
  assign out_victim = res_victim_r;
  assign out_count  = res_count_r;

endmodule

### rtl/clean_first_lru_replacer_core.sv
// Clean-first LRU frame replacer: top level joining controller and datapath.
//
// Usage:
//   Input items arrive on the in_ channel. in_tuser carries the action
//   (request victim, pin frame, unpin frame) and the dirty flag; in_tdata
//   carries the frame number. Unpinned frames sit in a clean and a dirty
//   recency list; a victim request takes the oldest clean frame, else the
//   oldest dirty one, and pins it.
//   Every item yields exactly one result on the out_ channel: out_tuser is
//   the found flag, out_tdata holds the victim frame and the count of
//   unpinned frames after the item.
//   Sequence: an item passes eval and done; a pin of an unpinned frame or
//   a found victim adds a link step between them, since the link memories
//   are read registered before the neighbors are relinked. One item is in
//   work at a time; in_tready is high only while the block is idle.
//   A finished result sits in an output register; if the receiver stalls,
//   the block holds the next result until the register is taken.
//   Reset (rst_n low, synchronous) pins every frame, empties both lists and
//   drops any pending result. The link memories need no clearing.
module clean_first_lru_replacer_core #(
  parameter int NUM_FRAMES = clfr_pkg::NUM_FRAMES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [clfr_pkg::IN_TDATA_W-1:0]     in_tdata,   // frame[5:0], zero pad
  input  logic [clfr_pkg::IN_TUSER_W-1:0]     in_tuser,   // action[1:0], dirty[2]
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [clfr_pkg::OUT_TDATA_W-1:0]    out_tdata,  // victim_frame[5:0],
                                                          // unpinned_count[12:6], zero pad
  output logic                                out_tuser   // found
);

  clfr_pkg::cmd_t                cmd;
  clfr_pkg::stat_t               stat;
  logic [clfr_pkg::FRAME_W-1:0]  victim;
  logic [clfr_pkg::COUNT_W-1:0]  count;

  clfr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .stat       (stat)
  );

  clfr_dp #(
    .NUM_FRAMES (NUM_FRAMES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_action  (in_tuser[1:0]),
    .in_frame   (in_tdata[clfr_pkg::FRAME_W-1:0]),
    .in_dirty   (in_tuser[2]),
    .out_found  (out_tuser),
    .out_victim (victim),
    .out_count  (count)
  );

  assign out_tdata = {{(clfr_pkg::OUT_TDATA_W - clfr_pkg::FRAME_W - clfr_pkg::COUNT_W){1'b0}},
                      count, victim};

endmodule

### tb/testbench.sv
// Self-checking testbench for the clean-first LRU frame replacer.
`timescale 1ns / 1ps

module testbench;

  localparam int FRAMES       = 64;
  localparam int LIMIT        = 200000;
  localparam int MAX_SHOWN    = 10;
  localparam int DRAIN_CYCLES = 20;
  localparam int HOLD_OFF     = 300;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  typedef struct packed {
    logic                          found;
    logic [clfr_pkg::FRAME_W-1:0]  victim;
    logic [clfr_pkg::COUNT_W-1:0]  unpinned;
  } replace_result_t;

  typedef struct {
    logic [1:0]                    action;
    logic [clfr_pkg::FRAME_W-1:0]  frame;
    logic                          dirty;
    bit                            fixed;
    replace_result_t               want;
  } stim_row_t;

  logic                             clk        = 1'b0;
  logic                             rst_n      = 1'b0;
  logic                             in_tvalid  = 1'b0;
  logic                             in_tready;
  logic [clfr_pkg::IN_TDATA_W-1:0]  in_tdata   = '0;
  logic [clfr_pkg::IN_TUSER_W-1:0]  in_tuser   = '0;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [clfr_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                             out_tuser;

  replace_result_t pending_results[$];
  stim_row_t       directed_rows[$];
  int              mismatches = 0;
  int              cycles     = 0;
  int              send_idle  = 0;
  int              recv_stall = 0;
  int              hold_asks  = 0;
  bit              offering   = 1'b0;

  // Replacer state as the block should hold it.
  bit                           pinned   [FRAMES];
  bit                           on_dirty [FRAMES];
  logic [clfr_pkg::FRAME_W-1:0] older_of [FRAMES];
  logic [clfr_pkg::FRAME_W-1:0] newer_of [FRAMES];
  logic [clfr_pkg::FRAME_W-1:0] newest_of[2];
  logic [clfr_pkg::FRAME_W-1:0] oldest_of[2];
  int unsigned                  members  [2];

  clean_first_lru_replacer_core #(.NUM_FRAMES(FRAMES)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic void lru_reset();
    for (int i = 0; i < FRAMES; i++) begin
      pinned[i]   = 1'b1;
      on_dirty[i] = 1'b0;
      older_of[i] = '0;
      newer_of[i] = '0;
    end
    for (int k = 0; k < 2; k++) begin
      newest_of[k] = '0;
      oldest_of[k] = '0;
      members[k]   = 0;
    end
  endfunction

  function automatic void lru_push(logic [clfr_pkg::FRAME_W-1:0] f, bit d);
    if (members[d] == 0) begin
      oldest_of[d] = f;
    end else begin
      newer_of[newest_of[d]] = f;
      older_of[f] = newest_of[d];
    end
    newest_of[d] = f;
    members[d]++;
  endfunction

  // A list of one keeps its stale ends; only the member count drops.
  function automatic void lru_unlink(logic [clfr_pkg::FRAME_W-1:0] f, bit d);
    bit is_old;
    bit is_new;
    if (members[d] == 0) return;
    if (members[d] == 1) begin
      members[d] = 0;
      return;
    end
    is_old = (oldest_of[d] == f);
    is_new = (newest_of[d] == f);
    if (is_old) oldest_of[d] = newer_of[f];
    else newer_of[older_of[f]] = is_new ? older_of[f] : newer_of[f];
    if (is_new) newest_of[d] = older_of[f];
    else older_of[newer_of[f]] = is_old ? newer_of[f] : older_of[f];
    members[d]--;
  endfunction

  function automatic replace_result_t lru_step(logic [1:0] act,
                                               logic [clfr_pkg::FRAME_W-1:0] f,
                                               logic d);
    replace_result_t r;
    logic [clfr_pkg::FRAME_W-1:0] v;
    r = '0;
    case (act)
      clfr_pkg::ACT_VICTIM: begin
        if (members[0] != 0) begin
          v = oldest_of[0];
          lru_unlink(v, 1'b0);
          pinned[v] = 1'b1;
          r.found   = 1'b1;
          r.victim  = v;
        end else if (members[1] != 0) begin
          v = oldest_of[1];
          lru_unlink(v, 1'b1);
          pinned[v] = 1'b1;
          r.found   = 1'b1;
          r.victim  = v;
        end
      end
      clfr_pkg::ACT_PIN: begin
        if (!pinned[f]) begin
          pinned[f] = 1'b1;
          lru_unlink(f, on_dirty[f]);
        end
      end
      clfr_pkg::ACT_UNPIN: begin
        if (pinned[f]) begin
          pinned[f]   = 1'b0;
          on_dirty[f] = d;
          lru_push(f, d);
        end
      end
      default: ;
    endcase
    r.unpinned = clfr_pkg::COUNT_W'(members[0] + members[1]);
    return r;
  endfunction

  function automatic void add_row(logic [1:0] a, int f, bit d, bit fixed,
                                  bit fnd, int vf, int cnt);
    stim_row_t row;
    row.action = a;
    row.frame  = clfr_pkg::FRAME_W'(f);
    row.dirty  = d;
    row.fixed  = fixed;
    row.want   = '{found: fnd, victim: clfr_pkg::FRAME_W'(vf),
                   unpinned: clfr_pkg::COUNT_W'(cnt)};
    directed_rows.push_back(row);
  endfunction

  task automatic send_item(logic [1:0] act, logic [clfr_pkg::FRAME_W-1:0] f, logic d,
                           bit fixed, replace_result_t want);
    replace_result_t r;
    in_tvalid <= 1'b1;
    in_tdata  <= clfr_pkg::IN_TDATA_W'(f);
    in_tuser  <= {d, act};
    offering  = 1'b1;
    do @(posedge clk); while (!in_tready);
    r = lru_step(act, f, d);
    pending_results.push_back(fixed ? want : r);
    if (send_idle != 0 && $urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      offering  = 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
  endtask

  // Pick at random every 40 items between stretches that fill the lists and stretches that drain them.
  task automatic send_random(int n);
    int pick;
    bit grow;
    logic [1:0] act;
    grow = 1'b1;
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) grow = 1'($urandom_range(1));
      pick = $urandom_range(99);
      if (grow) begin
        act = pick < 15 ? clfr_pkg::ACT_VICTIM :
              pick < 25 ? clfr_pkg::ACT_PIN :
              pick < 95 ? clfr_pkg::ACT_UNPIN : ACT_UNUSED;
      end else begin
        act = pick < 35 ? clfr_pkg::ACT_VICTIM :
              pick < 70 ? clfr_pkg::ACT_PIN :
              pick < 95 ? clfr_pkg::ACT_UNPIN : ACT_UNUSED;
      end
      send_item(act, clfr_pkg::FRAME_W'($urandom_range(FRAMES - 1)),
                1'($urandom_range(1)), 1'b0, '0);
    end
  endtask

  initial begin : receiver
    int holds_served;
    holds_served = 0;
    forever begin
      @(posedge clk);
      if (hold_asks != holds_served) begin
        holds_served++;
        out_tready <= 1'b0;
        repeat (HOLD_OFF - 1) @(posedge clk);
      end else begin
        out_tready <= ($urandom_range(99) >= recv_stall);
      end
    end
  end

  always @(posedge clk) begin : check_results
    replace_result_t got;
    replace_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tuser, out_tdata[clfr_pkg::FRAME_W-1:0],
             out_tdata[clfr_pkg::FRAME_W+clfr_pkg::COUNT_W-1:clfr_pkg::FRAME_W]};
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("unexpected item: found=%0d victim=%0d count=%0d",
                   got.found, got.victim, got.unpinned);
      end else begin
        want = pending_results.pop_front();
        if (got.found !== want.found || got.victim !== want.victim ||
            got.unpinned !== want.unpinned) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display("mismatch: found %0d/%0d victim %0d/%0d count %0d/%0d (exp/act)",
                     want.found, got.found, want.victim, got.victim,
                     want.unpinned, got.unpinned);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin : stimulus
    int order[FRAMES];
    int j;
    int tmp;
    lru_reset();
    add_row(clfr_pkg::ACT_VICTIM,  0, 0, 1, 0,  0, 0);
    add_row(clfr_pkg::ACT_PIN,     5, 0, 1, 0,  0, 0);
    add_row(ACT_UNUSED,           63, 1, 1, 0,  0, 0);
    add_row(clfr_pkg::ACT_UNPIN,   0, 0, 1, 0,  0, 1);
    add_row(clfr_pkg::ACT_UNPIN,  63, 1, 1, 0,  0, 2);
    add_row(clfr_pkg::ACT_UNPIN,  63, 0, 1, 0,  0, 2);
    add_row(clfr_pkg::ACT_UNPIN,  10, 0, 1, 0,  0, 3);
    add_row(clfr_pkg::ACT_UNPIN,  20, 1, 1, 0,  0, 4);
    add_row(clfr_pkg::ACT_VICTIM,  0, 0, 1, 1,  0, 3);
    add_row(clfr_pkg::ACT_VICTIM, 63, 1, 1, 1, 10, 2);
    // clean list empty: take the oldest dirty frame
    add_row(clfr_pkg::ACT_VICTIM,  0, 0, 1, 1, 63, 1);
    add_row(clfr_pkg::ACT_PIN,    20, 0, 1, 0,  0, 0);
    add_row(clfr_pkg::ACT_PIN,    20, 0, 1, 0,  0, 0);
    add_row(clfr_pkg::ACT_VICTIM,  0, 0, 1, 0,  0, 0);
    add_row(clfr_pkg::ACT_UNPIN,   1, 0, 0, 0,  0, 0);
    add_row(clfr_pkg::ACT_UNPIN,   2, 0, 0, 0,  0, 0);
    add_row(clfr_pkg::ACT_UNPIN,   3, 0, 0, 0,  0, 0);
    add_row(clfr_pkg::ACT_PIN,     2, 0, 0, 0,  0, 0);
    add_row(clfr_pkg::ACT_PIN,     3, 0, 0, 0,  0, 0);
    add_row(clfr_pkg::ACT_UNPIN,  42, 1, 0, 0,  0, 0);
    add_row(clfr_pkg::ACT_UNPIN,  43, 1, 0, 0,  0, 0);
    add_row(clfr_pkg::ACT_UNPIN,  44, 1, 0, 0,  0, 0);
    add_row(clfr_pkg::ACT_PIN,    42, 0, 0, 0,  0, 0);
    add_row(clfr_pkg::ACT_VICTIM,  0, 0, 0, 0,  0, 0);
    add_row(ACT_UNUSED,           21, 0, 0, 0,  0, 0);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      send_item(directed_rows[i].action, directed_rows[i].frame, directed_rows[i].dirty,
                directed_rows[i].fixed, directed_rows[i].want);

    // Stall the receiver while every frame is unpinned in random order, then drain.
    for (int i = 0; i < FRAMES; i++) order[i] = i;
    for (int i = FRAMES - 1; i > 0; i--) begin
      j = $urandom_range(i);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    hold_asks++;
    for (int i = 0; i < FRAMES; i++)
      send_item(clfr_pkg::ACT_UNPIN, clfr_pkg::FRAME_W'(order[i]),
                1'($urandom_range(1)), 1'b0, '0);
    for (int i = 0; i < FRAMES + 2; i++)
      send_item(clfr_pkg::ACT_VICTIM, clfr_pkg::FRAME_W'($urandom_range(FRAMES - 1)),
                1'b0, 1'b0, '0);
    send_random(200);

    send_idle = 74;
    recv_stall = 0;
    send_random(340);
    send_idle = 0;
    recv_stall = 74;
    send_random(340);
    send_idle = 28;
    recv_stall = 28;
    send_random(340);

    if (offering) in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### sim.f
rtl/clfr_pkg.sv
rtl/clfr_ctrl.sv
rtl/clfr_dp.sv
rtl/clean_first_lru_replacer_core.sv
tb/testbench.sv
